// ----- rtl/cmam_pkg.sv -----
package cmam_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned WDAY_W  = 3;
   localparam int unsigned CENT_W  = 8;
   localparam int unsigned REM_W   = 7;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1600;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd1970;
   localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
   localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
   localparam logic [MIN_W-1:0]   MIN_MAX    = 6'd59;
   localparam logic [WDAY_W-1:0]  WDAY_MAX   = 3'd6;
   localparam logic [WDAY_W-1:0]  WDAY_RESET = 3'd4;
   localparam logic [REM_W-1:0]   REM_MAX    = 7'd99;
   localparam logic [REM_W-1:0]   REM_RESET  = 7'd70;
   localparam logic [1:0]         Q4_RESET   = 2'd3;

   // reciprocal of 100, exact for values below 43699
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MINUTE_MASK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOUR_MASK    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_MASK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MONTH_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEEKDAY_MASK = 3'd4;

   typedef struct packed {
      logic [59:0] minute;
      logic [23:0] hour;
      logic [30:0] day;
      logic [11:0] month;
      logic [6:0]  weekday;
   } mask_type;

   typedef struct packed {
      logic               kind;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
   } raw_type;

   typedef struct packed {
      logic               kind;
      logic               ok;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [WDAY_W-1:0]  weekday;
      logic [REM_W-1:0]   rem100;
      logic [1:0]         cent_q4;
   } load_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [WDAY_W-1:0]  weekday;
      logic               matched;
      logic               load_error;
   } rsp_type;

   // common-year month length, zero for codes that are no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // (13 * (m + 1)) / 5 mod 7, with january and february as months 13 and 14
   function automatic logic [WDAY_W-1:0] month_term(input logic [MONTH_W-1:0] month);
      logic [WDAY_W-1:0] term;
      unique case (month)
         4'd1:    term = 3'd1;
         4'd2:    term = 3'd4;
         4'd3:    term = 3'd3;
         4'd4:    term = 3'd6;
         4'd5:    term = 3'd1;
         4'd6:    term = 3'd4;
         4'd7:    term = 3'd6;
         4'd8:    term = 3'd2;
         4'd9:    term = 3'd5;
         4'd10:   term = 3'd0;
         4'd11:   term = 3'd3;
         4'd12:   term = 3'd5;
         default: term = 3'd0;
      endcase
      return term;
   endfunction

endpackage

// ----- rtl/cmam_load_decode.sv -----
module cmam_load_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cmam_pkg::raw_type  in_item,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output cmam_pkg::load_type out_load
);

   typedef struct packed {
      cmam_pkg::raw_type                  raw;
      logic [cmam_pkg::CENT_W-1:0]        cent;
      logic [cmam_pkg::REM_W-1:0]         yrem;
      logic [cmam_pkg::REM_W-1:0]         rem100;
      logic [1:0]                         cent_q4;
      logic                               leap;
      logic [cmam_pkg::WDAY_W-1:0]        term;
      logic                               rng_ok;
   } stage_type;

   stage_type stage_ff, stage_in;
   logic      valid_ff, valid_in;

   logic [26:0]                  prod;
   logic [cmam_pkg::CENT_W-1:0]  quot;
   logic [cmam_pkg::REM_W-1:0]   rem;
   logic                         early;

   logic [cmam_pkg::DAY_W-1:0]   dim;
   logic                         day_ok;
   logic [10:0]                  wsum;
   logic [4:0]                   fold1;
   logic [3:0]                   fold2;
   logic [cmam_pkg::WDAY_W-1:0]  wday;

   assign in_ready = !valid_ff || out_ready;

   // century split, leap flag, range check and zeller terms of the raw load
   always_comb begin
      prod  = 27'(in_item.year) * 27'(cmam_pkg::RECIP_100);
      quot  = prod[cmam_pkg::RECIP_SHIFT +: cmam_pkg::CENT_W];
      rem   = cmam_pkg::REM_W'(in_item.year - 14'(quot) * 14'd100);
      early = in_item.month < 4'd3;

      stage_in.raw     = in_item;
      stage_in.rem100  = rem;
      stage_in.cent_q4 = quot[1:0];
      stage_in.leap    = (in_item.year[1:0] == 2'd0) && ((rem != '0) || (quot[1:0] == 2'd0));
      stage_in.term    = cmam_pkg::month_term(in_item.month);
      stage_in.cent    = quot;
      stage_in.yrem    = rem;
      if (early) begin
         if (rem == '0) begin
            stage_in.cent = quot - 8'd1;
            stage_in.yrem = cmam_pkg::REM_MAX;
         end else begin
            stage_in.yrem = rem - 7'd1;
         end
      end
      stage_in.rng_ok = (in_item.year >= cmam_pkg::YEAR_MIN) &&
                        (in_item.year <= cmam_pkg::YEAR_MAX) &&
                        (in_item.month >= 4'd1) && (in_item.month <= cmam_pkg::MONTH_MAX) &&
                        (in_item.day >= 5'd1) && (in_item.hour <= cmam_pkg::HOUR_MAX) &&
                        (in_item.minute <= cmam_pkg::MIN_MAX);
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   // day check and weekday, -2c taken as +5c and -1 as +6 mod 7
   always_comb begin
      dim = cmam_pkg::month_len(stage_ff.raw.month) +
            5'((stage_ff.raw.month == 4'd2) && stage_ff.leap);
      day_ok = stage_ff.raw.day <= dim;
      wsum = 11'(stage_ff.cent >> 2) + 11'(stage_ff.cent) * 11'd5 +
             11'(stage_ff.yrem) + 11'(stage_ff.yrem >> 2) +
             11'(stage_ff.term) + 11'(stage_ff.raw.day) + 11'd6;
      fold1 = 5'(wsum[2:0]) + 5'(wsum[5:3]) + 5'(wsum[8:6]) + 5'(wsum[10:9]);
      fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
      wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

      out_load.kind    = stage_ff.raw.kind;
      out_load.ok      = stage_ff.rng_ok && day_ok;
      out_load.year    = stage_ff.raw.year;
      out_load.month   = stage_ff.raw.month;
      out_load.day     = stage_ff.raw.day;
      out_load.hour    = stage_ff.raw.hour;
      out_load.minute  = stage_ff.raw.minute;
      out_load.weekday = wday;
      out_load.rem100  = stage_ff.rem100;
      out_load.cent_q4 = stage_ff.cent_q4;
   end

   assign out_valid = valid_ff;

endmodule

// ----- rtl/cmam_time_keeper.sv -----
module cmam_time_keeper (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cmam_pkg::load_type in_load,
   output logic               in_ready,
   input  cmam_pkg::mask_type masks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cmam_pkg::rsp_type  rsp
);

   logic [cmam_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [cmam_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cmam_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [cmam_pkg::HOUR_W-1:0]  hour_ff, hour_in;
   logic [cmam_pkg::MIN_W-1:0]   minute_ff, minute_in;
   logic [cmam_pkg::WDAY_W-1:0]  wday_ff, wday_in;
   logic [cmam_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [1:0]                   q4_ff, q4_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cmam_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         fire;
   logic                         leap_now;
   logic [cmam_pkg::DAY_W-1:0]   dim_now;
   logic                         at_end;
   logic [cmam_pkg::DAY_W-1:0]   day_idx;
   logic [cmam_pkg::MONTH_W-1:0] month_idx;

   assign in_ready = !rsp_valid_ff || !rsp_stall;
   assign fire     = in_valid && in_ready;

   assign leap_now = (year_ff[1:0] == 2'd0) && ((rem_ff != '0) || (q4_ff == 2'd0));
   assign dim_now  = cmam_pkg::month_len(month_ff) + 5'((month_ff == 4'd2) && leap_now);
   assign at_end   = (year_ff >= cmam_pkg::YEAR_MAX) && (month_ff == cmam_pkg::MONTH_MAX) &&
                     (day_ff == 5'd31) && (hour_ff == cmam_pkg::HOUR_MAX) &&
                     (minute_ff == cmam_pkg::MIN_MAX);

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      wday_in   = wday_ff;
      rem_in    = rem_ff;
      q4_in     = q4_ff;
      if (in_load.kind == cmam_pkg::KIND_LOAD) begin
         if (in_load.ok) begin
            year_in   = in_load.year;
            month_in  = in_load.month;
            day_in    = in_load.day;
            hour_in   = in_load.hour;
            minute_in = in_load.minute;
            wday_in   = in_load.weekday;
            rem_in    = in_load.rem100;
            q4_in     = in_load.cent_q4;
         end
      end else if (!at_end) begin
         if (minute_ff != cmam_pkg::MIN_MAX) begin
            minute_in = minute_ff + 6'd1;
         end else begin
            minute_in = '0;
            if (hour_ff != cmam_pkg::HOUR_MAX) begin
               hour_in = hour_ff + 5'd1;
            end else begin
               hour_in = '0;
               wday_in = (wday_ff == cmam_pkg::WDAY_MAX) ? '0 : wday_ff + 3'd1;
               if (day_ff < dim_now) begin
                  day_in = day_ff + 5'd1;
               end else begin
                  day_in = 5'd1;
                  if (month_ff != cmam_pkg::MONTH_MAX) begin
                     month_in = month_ff + 4'd1;
                  end else begin
                     month_in = 4'd1;
                     year_in  = year_ff + 14'd1;
                     if (rem_ff == cmam_pkg::REM_MAX) begin
                        rem_in = '0;
                        q4_in  = q4_ff + 2'd1;
                     end else begin
                        rem_in = rem_ff + 7'd1;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      day_idx   = day_in - 5'd1;
      month_idx = month_in - 4'd1;
      rsp_in.year       = year_in;
      rsp_in.month      = month_in;
      rsp_in.day        = day_in;
      rsp_in.hour       = hour_in;
      rsp_in.minute     = minute_in;
      rsp_in.weekday    = wday_in;
      rsp_in.matched    = masks.minute[minute_in] && masks.hour[hour_in] &&
                          masks.day[day_idx] && masks.month[month_idx] &&
                          masks.weekday[wday_in];
      rsp_in.load_error = (in_load.kind == cmam_pkg::KIND_LOAD) && !in_load.ok;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_ready) begin
         rsp_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         year_ff      <= cmam_pkg::YEAR_RESET;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         hour_ff      <= '0;
         minute_ff    <= '0;
         wday_ff      <= cmam_pkg::WDAY_RESET;
         rem_ff       <= cmam_pkg::REM_RESET;
         q4_ff        <= cmam_pkg::Q4_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            year_ff   <= year_in;
            month_ff  <= month_in;
            day_ff    <= day_in;
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            wday_ff   <= wday_in;
            rem_ff    <= rem_in;
            q4_ff     <= q4_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/calendar_minute_alarm_matcher.sv -----
// path: an accepted item passes the input, decode and result registers in order
// throughput: one item per cycle while rsp_stall is low, set by the input, decode and result registers
// reset: synchronous, active high; time returns to 1970-01-01 00:00 thursday,
// all masks clear, pipeline empties
module calendar_minute_alarm_matcher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [cmam_pkg::YEAR_W-1:0]         req_load_year,
   input  logic [cmam_pkg::MONTH_W-1:0]        req_load_month,
   input  logic [cmam_pkg::DAY_W-1:0]          req_load_day,
   input  logic [cmam_pkg::HOUR_W-1:0]         req_load_hour,
   input  logic [cmam_pkg::MIN_W-1:0]          req_load_minute,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cmam_pkg::YEAR_W-1:0]         rsp_year_out,
   output logic [cmam_pkg::MONTH_W-1:0]        rsp_month_out,
   output logic [cmam_pkg::DAY_W-1:0]          rsp_day_out,
   output logic [cmam_pkg::HOUR_W-1:0]         rsp_hour_out,
   output logic [cmam_pkg::MIN_W-1:0]          rsp_minute_out,
   output logic [cmam_pkg::WDAY_W-1:0]         rsp_weekday_out,
   output logic                                rsp_matched,
   output logic                                rsp_load_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cmam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cmam_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                 in_valid_ff, in_valid_in;
   cmam_pkg::raw_type    in_item_ff, in_item_in;
   logic                 in_ready;
   cmam_pkg::mask_type   masks_ff;
   logic                 dec_valid;
   logic                 dec_ready;
   cmam_pkg::load_type   dec_load;
   logic                 tk_ready;
   cmam_pkg::rsp_type    rsp;

   assign in_ready  = !in_valid_ff || dec_ready;
   assign req_stall = !in_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      in_item_in.kind   = req_kind;
      in_item_in.year   = req_load_year;
      in_item_in.month  = req_load_month;
      in_item_in.day    = req_load_day;
      in_item_in.hour   = req_load_hour;
      in_item_in.minute = req_load_minute;
      in_valid_in = in_valid_ff;
      if (in_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_item_ff <= in_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         masks_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cmam_pkg::CSR_MINUTE_MASK:  masks_ff.minute  <= csr_data[59:0];
            cmam_pkg::CSR_HOUR_MASK:    masks_ff.hour    <= csr_data[23:0];
            cmam_pkg::CSR_DAY_MASK:     masks_ff.day     <= csr_data[30:0];
            cmam_pkg::CSR_MONTH_MASK:   masks_ff.month   <= csr_data[11:0];
            cmam_pkg::CSR_WEEKDAY_MASK: masks_ff.weekday <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   cmam_load_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .in_ready  (dec_ready),
      .out_valid (dec_valid),
      .out_ready (tk_ready),
      .out_load  (dec_load)
   );

   cmam_time_keeper u_keeper (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_load   (dec_load),
      .in_ready  (tk_ready),
      .masks     (masks_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_year_out    = rsp.year;
   assign rsp_month_out   = rsp.month;
   assign rsp_day_out     = rsp.day;
   assign rsp_hour_out    = rsp.hour;
   assign rsp_minute_out  = rsp.minute;
   assign rsp_weekday_out = rsp.weekday;
   assign rsp_matched     = rsp.matched;
   assign rsp_load_error  = rsp.load_error;

endmodule
